>>> src/swmo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_pkg
// Shared types and constants for the stack with middle-element operations.
// ----------------------------------------------------------------------------
package swmo_pkg;

  localparam int Depth     = 64;
  localparam int SlotW     = $clog2(Depth);
  localparam int CountW    = $clog2(Depth + 1);
  localparam int DataW     = 32;
  localparam int QueueSize = 2;

  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_POP      = 2'd1;
  localparam logic [1:0] CMD_READ_MID = 2'd2;
  localparam logic [1:0] CMD_DEL_MID  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one queued command, as classified by the front end
  typedef struct packed {
    logic [1:0]       command;
    logic [DataW-1:0] push_value;
  } cmd_t;

endpackage
`default_nettype wire

>>> src/swmo_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_front
// Takes commands from the port and holds them in a short queue for the back
// end. The queue is two entries deep.
// ----------------------------------------------------------------------------
module swmo_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [1:0]                   command,
  input  wire logic signed [swmo_pkg::DataW-1:0] push_value,
  input  wire logic                         hold,
  output logic                              busy,
  output logic                              q_valid,
  output swmo_pkg::cmd_t                    q_head,
  input  wire logic                         q_pop
);

  swmo_pkg::cmd_t entries [swmo_pkg::QueueSize];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  // busy while a transaction waits for the back end, or while the back end
  // is still filling its free-slot list after reset
  logic       pending;

  assign busy    = pending || hold;
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= 1'b0;
      wr_ptr  <= 1'b0;
      fill    <= 2'd0;
      pending <= 1'b0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= '{command: command, push_value: push_value};
        wr_ptr          <= ~wr_ptr;
      end
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
      if (push) pending <= 1'b1;
      else if (q_pop) pending <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fill != 2'd2) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue underflow");
  a_busy_fill: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> busy) else $error("queued command while idle");
`endif

endmodule
`default_nettype wire

>>> src/swmo_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_back
// Carries out stack commands on the linked slot store. Each command passes
// three steps in turn: fetch words, read memories, write back and report.
// ----------------------------------------------------------------------------
module swmo_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  swmo_pkg::cmd_t              q_head,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        done,
  output logic signed [swmo_pkg::DataW-1:0] result_value,
  output logic [1:0]                  status,
  output logic [swmo_pkg::CountW-1:0] element_count
);

  localparam int SW = swmo_pkg::SlotW;
  localparam int CW = swmo_pkg::CountW;
  localparam int DW = swmo_pkg::DataW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;

  logic [DW-1:0] value_mem [swmo_pkg::Depth];
  logic [SW-1:0] up_mem    [swmo_pkg::Depth];
  logic [SW-1:0] down_mem  [swmo_pkg::Depth];
  logic [SW-1:0] free_mem  [swmo_pkg::Depth];

  logic [CW-1:0] free_count;
  logic [SW-1:0] top_slot;
  logic [SW-1:0] middle_slot;
  logic [CW-1:0] held_count;

  swmo_pkg::cmd_t cur;

  // registered read data
  logic [DW-1:0] rd_val_top;
  logic [DW-1:0] rd_val_mid;
  logic [SW-1:0] rd_free;
  logic [SW-1:0] rd_top_down;
  logic [SW-1:0] rd_mid_down;
  logic [SW-1:0] rd_mid_up;

  // free list reset contents: slot i at entry i, swept in by a small pointer
  logic [CW-1:0] init_idx;

  logic [SW-1:0] free_idx;
  assign free_idx = free_count[SW-1:0] - SW'(1);
  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    rd_val_top  <= value_mem[top_slot];
    rd_val_mid  <= value_mem[middle_slot];
    rd_free     <= free_mem[free_idx];
    rd_top_down <= down_mem[top_slot];
    rd_mid_down <= down_mem[middle_slot];
    rd_mid_up   <= up_mem[middle_slot];
  end

  logic empty;
  logic full;
  logic [SW-1:0] s_new;
  assign empty = (held_count == '0);
  assign full  = (free_count == '0);
  assign s_new = rd_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_count  <= CW'(swmo_pkg::Depth);
      top_slot    <= '0;
      middle_slot <= '0;
      held_count  <= '0;
      done        <= 1'b0;
      init_busy   <= 1'b1;
      init_idx    <= '0;
    end else begin
      if (init_busy) begin
        free_mem[init_idx[SW-1:0]] <= init_idx[SW-1:0];
        init_idx <= init_idx + CW'(1);
        if (init_idx == CW'(swmo_pkg::Depth - 1)) init_busy <= 1'b0;
      end
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur   <= q_head;
          state <= S_READ;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          result_value <= '0;
          status       <= swmo_pkg::ST_DONE;
          element_count <= held_count;
          if (cur.command == swmo_pkg::CMD_PUSH) begin
            if (full) begin
              status <= swmo_pkg::ST_FULL;
            end else begin
              value_mem[s_new] <= cur.push_value;
              free_count <= free_count - CW'(1);
              top_slot   <= s_new;
              if (empty) begin
                middle_slot <= s_new;
              end else begin
                up_mem[top_slot] <= s_new;
                down_mem[s_new]  <= top_slot;
                // odd count: middle moves up; new top may be its upper neighbour
                if (held_count[0])
                  middle_slot <= (held_count == CW'(1)) ? s_new : rd_mid_up;
              end
              held_count    <= held_count + CW'(1);
              element_count <= held_count + CW'(1);
            end
          end else if (empty) begin
            result_value <= '1;
            status       <= swmo_pkg::ST_EMPTY;
          end else if (cur.command == swmo_pkg::CMD_POP) begin
            result_value <= rd_val_top;
            if (held_count == CW'(1)) begin
              top_slot    <= '0;
              middle_slot <= '0;
            end else begin
              top_slot <= rd_top_down;
              if (!held_count[0]) middle_slot <= rd_mid_down;
            end
            free_mem[free_count[SW-1:0]] <= top_slot;
            free_count    <= free_count + CW'(1);
            held_count    <= held_count - CW'(1);
            element_count <= held_count - CW'(1);
          end else if (cur.command == swmo_pkg::CMD_READ_MID) begin
            result_value <= rd_val_mid;
          end else begin
            if (held_count == CW'(1)) begin
              top_slot    <= '0;
              middle_slot <= '0;
            end else if (held_count == CW'(2)) begin
              middle_slot <= rd_mid_down;
              top_slot    <= rd_mid_down;
            end else begin
              up_mem[rd_mid_down] <= rd_mid_up;
              down_mem[rd_mid_up] <= rd_mid_down;
              middle_slot <= held_count[0] ? rd_mid_up : rd_mid_down;
            end
            free_mem[free_count[SW-1:0]] <= middle_slot;
            free_count    <= free_count + CW'(1);
            held_count    <= held_count - CW'(1);
            element_count <= held_count - CW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (held_count + free_count) == CW'(swmo_pkg::Depth)) else $error("count mismatch");
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_EXEC) else $error("stray result");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    empty |-> top_slot == '0 && middle_slot == '0) else $error("slots not cleared");
`endif

endmodule
`default_nettype wire

>>> src/stack_with_middle_ops_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_middle_ops_unit
// LIFO stack of signed words with read and delete of the middle element.
//
//   channel | signals                                  | handshake
//   command | start, command, push_value               | start && !busy
//   result  | done, result_value, status, element_count| done strobe, one cycle
//
// done rises after the accepted command passes queue hand-off, memory read
// and write back. busy drops once the back end takes the command, so a new
// command can be queued while the one before it is still being carried out.
// After reset busy stays high while the free-slot list is filled.
// The receiver cannot stall; each result is valid for one cycle only.
// ----------------------------------------------------------------------------
module stack_with_middle_ops_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [1:0]                    command,
  input  wire logic signed [swmo_pkg::DataW-1:0] push_value,
  output logic                               busy,
  output logic                               done,
  output logic signed [swmo_pkg::DataW-1:0]  result_value,
  output logic [1:0]                         status,
  output logic [swmo_pkg::CountW-1:0]        element_count
);

  logic           q_valid;
  logic           q_pop;
  logic           init_busy;
  swmo_pkg::cmd_t q_head;

  swmo_front u_front (
    .clk, .rst, .start, .command, .push_value, .hold(init_busy), .busy,
    .q_valid, .q_head, .q_pop
  );

  swmo_back u_back (
    .clk, .rst, .q_valid, .q_head, .q_pop, .init_busy, .done,
    .result_value, .status, .element_count
  );

endmodule
`default_nettype wire
